[hdl/ldt_pkg.sv]
// Package for the landmark dedup table: payload structs, codes, depths.
// No dependencies.
package ldt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned BlackDepth = 16;
  localparam int unsigned TIdxW = $clog2(TableDepth);
  localparam int unsigned BIdxW = $clog2(BlackDepth);
  localparam int unsigned TCntW = $clog2(TableDepth + 1);
  localparam int unsigned BCntW = $clog2(BlackDepth + 1);

  typedef enum logic [1:0] {
    ReqDetect  = 2'd0,
    ReqNearest = 2'd1,
    ReqRetire  = 2'd2,
    ReqUnused  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    StAdded     = 4'd0,
    StUpdated   = 4'd1,
    StBlack     = 4'd2,
    StBounds    = 4'd3,
    StFull      = 4'd4,
    StNearest   = 4'd5,
    StEmpty     = 4'd6,
    StRetired   = 4'd7,
    StNoMatch   = 4'd8,
    StBlackFull = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    CfgRadius = 2'd0,
    CfgLimitX = 2'd1,
    CfgLimitY = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [9:0]         tag_x;
    logic [9:0]         tag_y;
  } req_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [3:0]         entry_index;
    logic signed [15:0] entry_x;
    logic signed [15:0] entry_y;
    logic [9:0]         entry_tag_x;
    logic [9:0]         entry_tag_y;
    logic               tracked_hit;
    logic [4:0]         table_count;
    logic [4:0]         black_count;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         tx;
    logic [9:0]         ty;
  } entry_t;

endpackage

[hdl/landmark_dedup_table_top.sv]
// Landmark dedup table, top level.
// Depends on ldt_pkg and ldt_dist.
//
// Requests arrive on req_valid_i/req_ready_o with a req_t beat; each gives one
// rsp_t beat on rsp_valid_o/rsp_ready_i (request code 3 is dropped silently).
// One request runs at a time. The sequencer reads one slot of the entry or
// blacklist memory per cycle; each read feeds the registered distance unit.
// Retire scans the table, then closes up the order with one read and one
// write per moved slot. Worst case is a detect that scans both lists in full;
// a retire is longest when it closes up from slot 0; a detect that stops
// early is shorter.
// The response sits in an output register; while the receiver stalls, the
// block holds it and takes no new request until it is taken.
// Reset clears the counts, the tracked slot and loads the register defaults
// (radius 450, limits 5500/2500). Memory contents stay undefined; only slots
// below the counts are used. Write config (cfg_we_i, cfg_idx_i, cfg_data_i)
// only while idle; indexes past 2 are ignored.
module landmark_dedup_table_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [14:0]     cfg_data_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  ldt_pkg::req_t   req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output ldt_pkg::rsp_t   rsp_o
);
  localparam int unsigned TW = ldt_pkg::TIdxW;
  localparam int unsigned BW = ldt_pkg::BIdxW;
  localparam int unsigned TC = ldt_pkg::TCntW;
  localparam int unsigned BC = ldt_pkg::BCntW;

  typedef enum logic [3:0] {
    S_IDLE, S_BSCAN, S_BWAIT, S_TSCAN, S_TWAIT, S_APPLY, S_SHRD, S_SHWR, S_OUT
  } state_e;

  state_e state_q;
  logic [14:0] radius_q, limx_q, limy_q;
  logic [TC-1:0] live_q;
  logic [BC-1:0] ret_q;
  logic trk_v_q;
  logic [TW-1:0] trk_q;
  ldt_pkg::req_t r_q;
  ldt_pkg::rsp_t rsp_q;
  logic rsp_v_q;

  // memories
  ldt_pkg::entry_t ent_mem [ldt_pkg::TableDepth];
  logic [31:0] blk_mem [ldt_pkg::BlackDepth];
  ldt_pkg::entry_t ent_rd_q;
  logic [31:0] blk_rd_q;
  logic ent_re, ent_we, blk_we;
  logic [TW-1:0] ent_ra, ent_wa;
  ldt_pkg::entry_t ent_wd;

  // read pointer, pipeline tags
  logic [8:0] rd_ptr_q;           // issue counter
  logic v1_q, v2_q;               // read data valid, distance valid
  logic [8:0] i1_q, i2_q;
  ldt_pkg::entry_t e2_q;
  logic [33:0] d2;
  logic [33:0] best_d_q;
  logic [TW-1:0] best_i_q;
  ldt_pkg::entry_t best_e_q;
  logic found_q;
  logic [TW-1:0] sh_q;
  logic signed [15:0] cx, cy;
  logic is_blk_q;

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) ent_rd_q <= ent_mem[ent_ra];
    if (blk_we) blk_mem[ret_q[BW-1:0]] <= {r_q.pos_x, r_q.pos_y};
    blk_rd_q <= blk_mem[rd_ptr_q[BW-1:0]];
  end

  assign cx = is_blk_q ? blk_rd_q[31:16] : ent_rd_q.x;
  assign cy = is_blk_q ? blk_rd_q[15:0]  : ent_rd_q.y;

  ldt_dist u_dist (
    .clk_i(clk_i), .ax_i(r_q.pos_x), .ay_i(r_q.pos_y),
    .bx_i(cx), .by_i(cy), .d2_o(d2)
  );

  logic [29:0] r2;
  assign r2 = radius_q * radius_q;
  logic hit;
  assign hit = v2_q && (d2 < 34'(r2));

  logic [15:0] absx, absy;
  assign absx = r_q.pos_x[15] ? 16'(-r_q.pos_x) : r_q.pos_x;
  assign absy = r_q.pos_y[15] ? 16'(-r_q.pos_y) : r_q.pos_y;

  assign req_ready_o = (state_q == S_IDLE) && !rsp_v_q;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o = rsp_q;

  always_comb begin
    ent_re = 1'b0; ent_ra = rd_ptr_q[TW-1:0];
    ent_we = 1'b0; ent_wa = sh_q; ent_wd = ent_rd_q;
    blk_we = 1'b0;
    unique case (state_q)
      S_TSCAN: ent_re = (rd_ptr_q < 9'(live_q));
      S_SHRD:  begin ent_re = 1'b1; ent_ra = TW'(sh_q + 1'b1); end
      S_SHWR:  ent_we = 1'b1;
      S_APPLY: begin
        // a full blacklist takes no more entries
        blk_we = (r_q.req_type == ldt_pkg::ReqRetire) &&
                 (ret_q < BC'(ldt_pkg::BlackDepth));
        if (r_q.req_type == ldt_pkg::ReqDetect) begin
          ent_we = 1'b1;
          ent_wa = found_q ? best_i_q : live_q[TW-1:0];
          ent_wd = found_q ? best_e_q
                           : ldt_pkg::entry_t'{r_q.pos_x, r_q.pos_y, 10'd0, 10'd0};
          ent_wd.tx = r_q.tag_x; ent_wd.ty = r_q.tag_y;
          if (!found_q && live_q >= TC'(ldt_pkg::TableDepth)) ent_we = 1'b0;
        end
      end
      default: ;
    endcase
  end

  function automatic ldt_pkg::rsp_t mk(logic [3:0] st, logic [TW-1:0] i,
                                       ldt_pkg::entry_t e, logic h,
                                       logic [TC-1:0] lc, logic [BC-1:0] bc);
    ldt_pkg::rsp_t o;
    o.status = st; o.entry_index = 4'(i);
    o.entry_x = e.x; o.entry_y = e.y; o.entry_tag_x = e.tx; o.entry_tag_y = e.ty;
    o.tracked_hit = h; o.table_count = 5'(lc); o.black_count = 5'(bc);
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      radius_q <= 15'd450; limx_q <= 15'd5500; limy_q <= 15'd2500;
      live_q <= '0; ret_q <= '0; trk_v_q <= 1'b0; trk_q <= '0;
      rsp_v_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; found_q <= 1'b0;
      rd_ptr_q <= '0; is_blk_q <= 1'b0;
    end else begin
      if (rsp_v_q && rsp_ready_i) rsp_v_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ldt_pkg::CfgRadius: radius_q <= cfg_data_i;
          ldt_pkg::CfgLimitX: limx_q <= cfg_data_i;
          ldt_pkg::CfgLimitY: limy_q <= cfg_data_i;
          default: ;
        endcase
      end
      // advance the read/distance pipeline
      v2_q <= v1_q; i2_q <= i1_q; e2_q <= ent_rd_q;
      v1_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (req_valid_i && req_ready_o) begin
          r_q <= req_i; rd_ptr_q <= '0; found_q <= 1'b0;
          unique case (req_i.req_type)
            ldt_pkg::ReqDetect:  begin is_blk_q <= 1'b1; state_q <= S_BSCAN; end
            ldt_pkg::ReqNearest: begin is_blk_q <= 1'b0; state_q <= S_TSCAN; end
            ldt_pkg::ReqRetire:  begin is_blk_q <= 1'b0; state_q <= S_TSCAN; end
            default: ;
          endcase
        end
        S_BSCAN: begin
          if (!(absx < 16'(limx_q) && absy < 16'(limy_q))) begin
            rsp_q <= mk(ldt_pkg::StBounds, '0, '0, 1'b0, live_q, ret_q);
            state_q <= S_OUT;
          end else if (hit) begin
            rsp_q <= mk(ldt_pkg::StBlack, '0, '0, 1'b0, live_q, ret_q);
            state_q <= S_OUT;
          end else if (rd_ptr_q < 9'(ret_q)) begin
            v1_q <= 1'b1; i1_q <= rd_ptr_q;
            rd_ptr_q <= rd_ptr_q + 1'b1;
          end else state_q <= S_BWAIT;
        end
        S_BWAIT: begin
          if (hit) begin
            rsp_q <= mk(ldt_pkg::StBlack, '0, '0, 1'b0, live_q, ret_q);
            state_q <= S_OUT;
          end else if (!v1_q && !v2_q) begin
            is_blk_q <= 1'b0; rd_ptr_q <= '0; state_q <= S_TSCAN;
          end
        end
        S_TSCAN, S_TWAIT: begin
          if (state_q == S_TSCAN) begin
            if (rd_ptr_q < 9'(live_q)) begin
              v1_q <= 1'b1; i1_q <= rd_ptr_q; rd_ptr_q <= rd_ptr_q + 1'b1;
            end else state_q <= S_TWAIT;
          end
          if (v2_q) begin
            if (r_q.req_type == ldt_pkg::ReqNearest) begin
              if (i2_q == '0 || d2 <= best_d_q) begin
                best_d_q <= d2; best_i_q <= TW'(i2_q); best_e_q <= e2_q;
              end
            end else if (hit) begin
              found_q <= 1'b1; best_i_q <= TW'(i2_q); best_e_q <= e2_q;
              v1_q <= 1'b0; state_q <= S_APPLY;
            end
          end
          if (state_q == S_TWAIT && !v1_q && !v2_q) state_q <= S_APPLY;
        end
        S_APPLY: begin
          state_q <= S_OUT;
          unique case (r_q.req_type)
            ldt_pkg::ReqDetect:
              if (found_q)
                rsp_q <= mk(ldt_pkg::StUpdated, best_i_q,
                  ldt_pkg::entry_t'{best_e_q.x, best_e_q.y, r_q.tag_x, r_q.tag_y},
                  trk_v_q && trk_q == best_i_q, live_q, ret_q);
              else if (live_q >= TC'(ldt_pkg::TableDepth))
                rsp_q <= mk(ldt_pkg::StFull, '0, '0, 1'b0, live_q, ret_q);
              else begin
                rsp_q <= mk(ldt_pkg::StAdded, live_q[TW-1:0],
                  ldt_pkg::entry_t'{r_q.pos_x, r_q.pos_y, r_q.tag_x, r_q.tag_y},
                  1'b0, live_q + 1'b1, ret_q);
                live_q <= live_q + 1'b1;
              end
            ldt_pkg::ReqNearest:
              if (live_q == '0)
                rsp_q <= mk(ldt_pkg::StEmpty, '0, '0, 1'b0, live_q, ret_q);
              else begin
                trk_v_q <= 1'b1; trk_q <= best_i_q;
                rsp_q <= mk(ldt_pkg::StNearest, best_i_q, best_e_q, 1'b0,
                  live_q, ret_q);
              end
            default:
              if (ret_q >= BC'(ldt_pkg::BlackDepth))
                rsp_q <= mk(ldt_pkg::StBlackFull, '0, '0, 1'b0, live_q, ret_q);
              else begin
                ret_q <= ret_q + 1'b1;
                if (found_q) begin
                  live_q <= live_q - 1'b1;
                  rsp_q <= mk(ldt_pkg::StRetired, best_i_q, best_e_q, 1'b0,
                    live_q - 1'b1, ret_q + 1'b1);
                  sh_q <= best_i_q;
                  if (9'(best_i_q) + 9'd1 < 9'(live_q)) state_q <= S_SHRD;
                end else
                  rsp_q <= mk(ldt_pkg::StNoMatch, '0, '0, 1'b0, live_q,
                    ret_q + 1'b1);
              end
          endcase
        end
        S_SHRD: state_q <= S_SHWR;
        S_SHWR: begin
          // live_q already decremented: move while sh+1 < live
          if (9'(sh_q) + 9'd1 < 9'(live_q)) begin
            sh_q <= sh_q + 1'b1; state_q <= S_SHRD;
          end else state_q <= S_OUT;
        end
        S_OUT: begin rsp_v_q <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[hdl/ldt_dist.sv]
// Registered squared-distance unit: two 17x17 squares, then the sum.
// No dependencies.
module ldt_dist (
  input  logic               clk_i,
  input  logic signed [15:0] ax_i,
  input  logic signed [15:0] ay_i,
  input  logic signed [15:0] bx_i,
  input  logic signed [15:0] by_i,
  output logic [33:0]        d2_o
);
  logic signed [16:0] dx, dy;
  logic [33:0] sqx_q, sqy_q;

  assign dx = 17'(ax_i) - 17'(bx_i);
  assign dy = 17'(ay_i) - 17'(by_i);

  always_ff @(posedge clk_i) begin
    sqx_q <= 34'(unsigned'(34'(dx * dx)));
    sqy_q <= 34'(unsigned'(34'(dy * dy)));
  end

  assign d2_o = sqx_q + sqy_q;
endmodule
